@@ rtl/rotated_frame_depth_warp_defines.svh @@
// assertion macros of the rotated frame depth warp rtl, used by its queue
`ifndef ROTATED_FRAME_DEPTH_WARP_DEFINES_SVH
`define ROTATED_FRAME_DEPTH_WARP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RFDW_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("rfdw check failed");
`define RFDW_ASSERT_NEXT(label, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error("rfdw check failed");
`else
`define RFDW_ASSERT_NEVER(label, expr)
`define RFDW_ASSERT_NEXT(label, cond, expr)
`endif
`endif

@@ rtl/rfdw_pkg.sv @@
// types, constants and helper functions of the rotated frame depth warp
package rfdw_pkg;

	localparam int COORD_WIDTH = 24;
	localparam int COORD_FRAC_BITS = 8;
	localparam int TRIG_WIDTH = 16;
	localparam int TRIG_FRAC = 14;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CENTER_X_RESET_UNITS = 100;
	localparam int FAR_DEPTH_RESET_UNITS = 200;
	localparam int QUEUE_DEPTH = 4;

	localparam int ROT_PROD_WIDTH = COORD_WIDTH + 1 + TRIG_WIDTH;
	localparam int BACK_PROD_WIDTH = COORD_WIDTH + TRIG_WIDTH;
	localparam int NUM_WIDTH = 2 * COORD_WIDTH;
	localparam int QUOT_WIDTH = COORD_WIDTH + 1;

	localparam logic signed [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_COS_ANGLE   = 3'd2,
		REG_SIN_ANGLE   = 3'd3,
		REG_FAR_DEPTH   = 3'd4,
		REG_UNWARP_MODE = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
	} point_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] out_x;
		logic signed [COORD_WIDTH-1:0] out_y;
		logic                          saturated;
	} result_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] center_x;
		logic signed [COORD_WIDTH-1:0] center_y;
		logic signed [TRIG_WIDTH-1:0]  cos_angle;
		logic signed [TRIG_WIDTH-1:0]  sin_angle;
		logic [COORD_WIDTH-2:0]        far_depth;
		logic                          unwarp_mode;
	} cfg_t;

	// classified item handed from the front to the back
	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rx;
		logic [NUM_WIDTH-1:0]          mag;
		logic                          neg;
		logic [COORD_WIDTH-1:0]        den;
		logic                          flag;
	} task_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rx;
		logic [QUOT_WIDTH-1:0]         q;
		logic                          neg;
		logic                          mag_zero;
		logic                          ovf;
		logic                          flag;
	} div_out_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] value;
		logic                          ovf;
	} sat_t;

	function automatic sat_t sat_coord(input logic signed [63:0] v);
		sat_t r;
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi) begin
			r.value = COORD_MAX;
			r.ovf = 1'b1;
		end else if (v < lo) begin
			r.value = COORD_MIN;
			r.ovf = 1'b1;
		end else begin
			r.value = v[COORD_WIDTH-1:0];
			r.ovf = 1'b0;
		end
		return r;
	endfunction

	// add half an lsb, then floor shift
	function automatic logic signed [63:0] round_trig(input logic signed [63:0] v);
		return (v + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
	endfunction

endpackage

@@ rtl/rfdw_front.sv @@
// front pipeline: centre, rotate into the frame and classify the depth ratio
module rfdw_front (
	input  logic              clk,
	input  logic              arst_n,
	input  rfdw_pkg::cfg_t    cfg,
	input  logic              point_valid,
	input  rfdw_pkg::point_t  point,
	output logic              point_stall,
	output logic              task_valid,
	output rfdw_pkg::task_t   task_data,
	input  logic              task_full
);
	import rfdw_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int PW = ROT_PROD_WIDTH;

	logic en;
	logic valid_s1, valid_s2, valid_s3, valid_s4;

	logic signed [W:0] dx_s1, dy_s1;
	logic signed [PW-1:0] xc_s2, ys_s2, yc_s2, xs_s2;
	logic signed [W-1:0] rx_s3;
	logic [W-1:0] ax_s3, rymag_s3;
	logic ryneg_s3, flag_s3;
	logic signed [W-1:0] rx_s4;
	logic [NUM_WIDTH-1:0] mag_s4;
	logic [W-1:0] den_s4;
	logic neg_s4, flag_s4;

	logic signed [PW:0] sum_x, sum_y;
	sat_t sat_x, sat_y;
	logic [W-1:0] ax_next, rymag_next;
	logic [W-1:0] num_mult, den_sel;

	assign en = !valid_s4 || !task_full;
	assign point_stall = !en;

	always_comb begin
		sum_x = (PW+1)'(xc_s2) + (PW+1)'(ys_s2);
		sum_y = (PW+1)'(yc_s2) - (PW+1)'(xs_s2);
		sat_x = sat_coord(round_trig(64'(sum_x)));
		sat_y = sat_coord(round_trig(64'(sum_y)));
		ax_next = sat_x.value[W-1] ? W'(-sat_x.value) : W'(sat_x.value);
		rymag_next = sat_y.value[W-1] ? W'(-sat_y.value) : W'(sat_y.value);
	end

	// warp: y*far/|x|, unwarp: y*|x|/far
	always_comb begin
		if (cfg.unwarp_mode) begin
			num_mult = ax_s3;
			den_sel = W'(cfg.far_depth);
		end else begin
			num_mult = W'(cfg.far_depth);
			den_sel = ax_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= point_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= (W+1)'(point.point_x) - (W+1)'(cfg.center_x);
			dy_s1 <= (W+1)'(point.point_y) - (W+1)'(cfg.center_y);
			xc_s2 <= dx_s1 * cfg.cos_angle;
			ys_s2 <= dy_s1 * cfg.sin_angle;
			yc_s2 <= dy_s1 * cfg.cos_angle;
			xs_s2 <= dx_s1 * cfg.sin_angle;
			rx_s3 <= sat_x.value;
			ax_s3 <= ax_next;
			rymag_s3 <= rymag_next;
			ryneg_s3 <= sat_y.value[W-1];
			flag_s3 <= sat_x.ovf | sat_y.ovf;
			rx_s4 <= rx_s3;
			// zero depth in warp mode saturates on the sign of y alone
			mag_s4 <= (!cfg.unwarp_mode && ax_s3 == '0) ? NUM_WIDTH'(rymag_s3)
				: rymag_s3 * num_mult;
			den_s4 <= den_sel;
			neg_s4 <= ryneg_s3;
			flag_s4 <= flag_s3;
		end
	end

	assign task_valid = valid_s4;
	assign task_data = '{rx: rx_s4, mag: mag_s4, neg: neg_s4, den: den_s4, flag: flag_s4};

endmodule

@@ rtl/rfdw_fifo.sv @@
// short queue between the front and the back
`include "rotated_frame_depth_warp_defines.svh"
module rfdw_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rfdw_pkg::task_t  push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output rfdw_pkg::task_t  pop_data
);
	import rfdw_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	task_t mem_q [QUEUE_DEPTH];
	logic [AW-1:0] wr_q, rd_q;
	logic [CW-1:0] count_q;
	logic push_ok;

	assign full = count_q == CW'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data = mem_q[rd_q];
	assign push_ok = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push_ok) begin
				wr_q <= wr_q + AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + AW'(1);
			end
			case ({push_ok, pop})
				2'b10: count_q <= count_q + CW'(1);
				2'b01: count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push_ok) begin
			mem_q[wr_q] <= push_data;
		end
	end

	`RFDW_ASSERT_NEVER(a_count_bound, count_q > CW'(QUEUE_DEPTH))
	`RFDW_ASSERT_NEVER(a_pop_empty, pop && (count_q == '0))
	`RFDW_ASSERT_NEXT(a_push_only, push_ok && !pop, count_q == $past(count_q) + CW'(1))
	`RFDW_ASSERT_NEXT(a_pop_only, pop && !push_ok, count_q == $past(count_q) - CW'(1))

endmodule

@@ rtl/rfdw_div.sv @@
// pipelined restoring divider, one quotient bit per stage, rounds half away from zero
module rfdw_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  rfdw_pkg::task_t     in_data,
	output logic                out_valid,
	output rfdw_pkg::div_out_t  out_data
);
	import rfdw_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int NW = NUM_WIDTH;
	localparam int QB = QUOT_WIDTH;

	typedef struct packed {
		logic [W-1:0]        rem;
		logic [QB-1:0]       low;
		logic [QB-1:0]       q;
		logic [W-1:0]        den;
		logic signed [W-1:0] rx;
		logic                neg;
		logic                mag_zero;
		logic                ovf;
		logic                flag;
	} div_stage_t;

	logic valid_s0;
	logic [NW-1:0] n_s0;
	logic [W-1:0] den_s0;
	logic signed [W-1:0] rx_s0;
	logic neg_s0, mag_zero_s0, flag_s0;

	logic valid_s [QB];
	div_stage_t stage_s [QB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= in_valid;
		end
	end

	// rounding bias: add half the divisor before dividing
	always_ff @(posedge clk) begin
		if (en) begin
			n_s0 <= in_data.mag + NW'(in_data.den >> 1);
			den_s0 <= in_data.den;
			rx_s0 <= in_data.rx;
			neg_s0 <= in_data.neg;
			mag_zero_s0 <= in_data.mag == '0;
			flag_s0 <= in_data.flag;
		end
	end

	for (genvar k = 0; k < QB; k++) begin : g_step
		localparam int BIT = QB - 1 - k;
		div_stage_t cur;
		div_stage_t nxt;
		logic [W:0] trial;
		logic prev_valid;

		if (k == 0) begin : g_first
			// quotient too wide (or zero divisor) when the top part already reaches den
			assign cur = '{rem: W'(n_s0[NW-1:QB]), low: n_s0[QB-1:0], q: '0, den: den_s0,
				rx: rx_s0, neg: neg_s0, mag_zero: mag_zero_s0,
				ovf: W'(n_s0[NW-1:QB]) >= den_s0, flag: flag_s0};
			assign prev_valid = valid_s0;
		end else begin : g_next
			assign cur = stage_s[k-1];
			assign prev_valid = valid_s[k-1];
		end

		assign trial = {cur.rem, cur.low[BIT]};

		always_comb begin
			nxt = cur;
			if (trial >= {1'b0, cur.den}) begin
				nxt.rem = W'(trial - {1'b0, cur.den});
				nxt.q[BIT] = 1'b1;
			end else begin
				nxt.rem = trial[W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				stage_s[k] <= nxt;
			end
		end
	end

	assign out_valid = valid_s[QB-1];
	assign out_data = '{rx: stage_s[QB-1].rx, q: stage_s[QB-1].q, neg: stage_s[QB-1].neg,
		mag_zero: stage_s[QB-1].mag_zero, ovf: stage_s[QB-1].ovf,
		flag: stage_s[QB-1].flag};

endmodule

@@ rtl/rfdw_back.sv @@
// back pipeline: depth ratio by division, rotate back and move to the centre
module rfdw_back (
	input  logic              clk,
	input  logic              arst_n,
	input  rfdw_pkg::cfg_t    cfg,
	input  logic              task_valid,
	input  rfdw_pkg::task_t   task_data,
	output logic              task_pop,
	output logic              result_valid,
	output rfdw_pkg::result_t result,
	input  logic              result_stall
);
	import rfdw_pkg::*;

	localparam int W = COORD_WIDTH;
	localparam int QB = QUOT_WIDTH;
	localparam int BW = BACK_PROD_WIDTH;

	logic en;
	logic div_valid;
	div_out_t div_data;

	logic valid_s1, valid_s2, valid_s3;
	logic signed [W-1:0] rx_s1, sy_s1;
	logic flag_s1;
	logic signed [BW-1:0] rc_s2, ss_s2, sc_s2, rs_s2;
	logic flag_s2;
	result_t result_s3;

	logic signed [QB:0] q_signed;
	sat_t sat_q;
	logic signed [W-1:0] sy_next;
	logic sy_flag;
	logic signed [BW:0] diff_x, sum_y;
	sat_t sat_x, sat_y;

	assign en = !(valid_s3 && result_stall);
	assign task_pop = en && task_valid;

	rfdw_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (task_valid),
		.in_data   (task_data),
		.out_valid (div_valid),
		.out_data  (div_data)
	);

	always_comb begin
		q_signed = div_data.neg ? -$signed({1'b0, div_data.q}) : $signed({1'b0, div_data.q});
		sat_q = sat_coord(64'(q_signed));
		if (div_data.ovf) begin
			// zero divisor or huge ratio: saturate on the sign of the product, or give zero for a zero numerator
			sy_flag = 1'b1;
			if (div_data.mag_zero) begin
				sy_next = '0;
			end else if (div_data.neg) begin
				sy_next = COORD_MIN;
			end else begin
				sy_next = COORD_MAX;
			end
		end else begin
			sy_flag = sat_q.ovf;
			sy_next = sat_q.value;
		end
	end

	always_comb begin
		diff_x = (BW+1)'(rc_s2) - (BW+1)'(ss_s2);
		sum_y = (BW+1)'(sc_s2) + (BW+1)'(rs_s2);
		sat_x = sat_coord(round_trig(64'(diff_x)) + 64'(cfg.center_x));
		sat_y = sat_coord(round_trig(64'(sum_y)) + 64'(cfg.center_y));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= div_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rx_s1 <= div_data.rx;
			sy_s1 <= sy_next;
			flag_s1 <= div_data.flag | sy_flag;
			rc_s2 <= rx_s1 * cfg.cos_angle;
			ss_s2 <= sy_s1 * cfg.sin_angle;
			sc_s2 <= sy_s1 * cfg.cos_angle;
			rs_s2 <= rx_s1 * cfg.sin_angle;
			flag_s2 <= flag_s1;
			result_s3 <= '{out_x: sat_x.value, out_y: sat_y.value,
				saturated: flag_s2 | sat_x.ovf | sat_y.ovf};
		end
	end

	assign result_valid = valid_s3;
	assign result = result_s3;

endmodule

@@ rtl/rotated_frame_depth_warp.sv @@
// top level: configuration registers, front, queue and back of the depth warp
//
// one point beat in on point_valid/point_stall, one result beat out on
// result_valid/result_stall; a beat moves when valid is high and stall low.
// each point is centred, rotated into the frame, its y scaled by
// far_depth/|x| (warp) or |x|/far_depth (unwarp), rotated back and recentred.
// throughput is one point per cycle while no stall holds the flow; the
// divider is an input register and a 25 stage pipeline that makes one
// quotient bit per stage, so a point passes 4 front stages, the queue, 26
// divider stages and 3 back stages before its result beat can move.
// the front and the back freeze on their own: a stalled result holds the back,
// the 4 entry queue keeps taking points until it is full, and once the last
// front stage also holds a beat point_stall rises.
// reset clears all valid bits and loads the default frame: centre (100, 0),
// angle zero, far depth 200, warp mode. configuration is written through
// cfg_we/cfg_index/cfg_data by the user only while nothing is in flight; the
// block does not enforce it. saturated flags a zero divisor or any clipping.
module rotated_frame_depth_warp #(
	parameter int COORD_FRAC_BITS = rfdw_pkg::COORD_FRAC_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 point_valid,
	output logic                                 point_stall,
	input  rfdw_pkg::point_t                     point,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output rfdw_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [rfdw_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [rfdw_pkg::COORD_WIDTH-1:0]     cfg_data
);
	import rfdw_pkg::*;

	localparam logic signed [COORD_WIDTH-1:0] CENTER_X_RESET =
		COORD_WIDTH'(CENTER_X_RESET_UNITS << COORD_FRAC_BITS);
	localparam logic [COORD_WIDTH-2:0] FAR_DEPTH_RESET =
		(COORD_WIDTH-1)'(FAR_DEPTH_RESET_UNITS << COORD_FRAC_BITS);
	localparam logic signed [TRIG_WIDTH-1:0] TRIG_ONE = TRIG_WIDTH'(1 << TRIG_FRAC);

	cfg_t cfg_q;
	logic task_valid, task_full, task_pop, fifo_valid;
	task_t task_data, fifo_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{center_x: CENTER_X_RESET, center_y: '0, cos_angle: TRIG_ONE,
				sin_angle: '0, far_depth: FAR_DEPTH_RESET, unwarp_mode: 1'b0};
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:    cfg_q.center_x <= cfg_data;
				REG_CENTER_Y:    cfg_q.center_y <= cfg_data;
				REG_COS_ANGLE:   cfg_q.cos_angle <= cfg_data[TRIG_WIDTH-1:0];
				REG_SIN_ANGLE:   cfg_q.sin_angle <= cfg_data[TRIG_WIDTH-1:0];
				REG_FAR_DEPTH:   cfg_q.far_depth <= cfg_data[COORD_WIDTH-2:0];
				REG_UNWARP_MODE: cfg_q.unwarp_mode <= cfg_data[0];
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	rfdw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.point_valid (point_valid),
		.point       (point),
		.point_stall (point_stall),
		.task_valid  (task_valid),
		.task_data   (task_data),
		.task_full   (task_full)
	);

	rfdw_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (task_valid),
		.push_data (task_data),
		.full      (task_full),
		.pop       (task_pop),
		.pop_valid (fifo_valid),
		.pop_data  (fifo_data)
	);

	rfdw_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.task_valid   (fifo_valid),
		.task_data    (fifo_data),
		.task_pop     (task_pop),
		.result_valid (result_valid),
		.result       (result),
		.result_stall (result_stall)
	);

endmodule
